[src/bfloat16_cube_root_macros.svh]
// Assertion macros shared by the cube root RTL.
`ifndef BFLOAT16_CUBE_ROOT_MACROS_SVH
`define BFLOAT16_CUBE_ROOT_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define BCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define BCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bcr_pkg.sv]
// Types and constants shared by the bfloat16 cube root pipeline.
`timescale 1ns / 1ps
`default_nettype none

package bcr_pkg;

  localparam int Y_W       = 48;  // signed accumulator, 40 fraction bits
  localparam int R_W       = 10;  // scaled significand, 7 fraction bits
  localparam int M_W       = 7;   // signed exponent third
  localparam int K_W       = 6;   // leading-one position in the accumulator
  localparam int NUM_CELLS = 6;   // Horner steps after the leading coefficient

  typedef logic signed [Y_W-1:0] acc_t;

  // Polynomial coefficients, highest degree first, scaled by 2^40.
  localparam acc_t COEF [NUM_CELLS+1] = '{
    -48'sd19100749,
    48'sd576262900,
    -48'sd7169741793,
    48'sd48233829404,
    -48'sd198312635322,
    48'sd632539573282,
    48'sd625192837686
  };

  typedef struct packed {
    logic                    special;  // zero, infinity or NaN: pass through
    logic [15:0]             x;
    logic signed [M_W-1:0]   m;
  } meta_t;

  typedef struct packed {
    meta_t          meta;
    logic [R_W-1:0] r;
    acc_t           y;
  } cell_t;

  typedef struct packed {
    meta_t          meta;
    logic [Y_W-1:0] v;
    logic [K_W-1:0] k;
  } norm_t;

endpackage

`default_nettype wire

[src/bcr_if.sv]
// Valid/ready stream interfaces for operand and result words.
`timescale 1ns / 1ps
`default_nettype none

interface bcr_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] x_bits;

  modport source (output valid, output x_bits, input ready);
  modport sink (input valid, input x_bits, output ready);
endinterface

interface bcr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] root_bits;

  modport source (output valid, output root_bits, input ready);
  modport sink (input valid, input root_bits, output ready);
endinterface

`default_nettype wire

[src/bcr_decode.sv]
// Operand decode stage: splits the exponent into a multiple of three and a remainder.
`timescale 1ns / 1ps
`default_nettype none

module bcr_decode
  import bcr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire logic [15:0] x_i,
  output logic             valid_o,
  input  wire logic        ready_i,
  output cell_t            data_o
);

  logic  valid_q, valid_d;
  logic  load;
  cell_t data_q, data_d;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load ? 1'b1 : (ready_i ? 1'b0 : valid_q);

  always_comb begin
    logic [7:0]  ef;
    logic [6:0]  fr;
    logic [2:0]  p;
    logic [7:0]  mant;
    logic [8:0]  t;
    logic [16:0] qp;
    logic [7:0]  q;
    logic [8:0]  rem;
    ef = x_i[14:7];
    fr = x_i[6:0];
    p  = '0;
    for (int i = 0; i < 7; i++) begin
      if (fr[i]) begin
        p = 3'(i);
      end
    end
    // Biased by 135 so that the exponent is non-negative and a multiple of three apart.
    if (ef == 8'd0) begin
      mant = 8'({1'b0, fr} << (3'd7 - p));
      t    = {6'd0, p} + 9'd2;
    end else begin
      mant = {1'b1, fr};
      t    = {1'b0, ef} + 9'd8;
    end
    qp  = 17'(t) * 17'd171;
    q   = qp[16:9];
    rem = t - {q, 1'b0} - {1'b0, q};
    data_d.meta.special = (x_i[14:0] == 15'd0) || (ef == 8'hFF);
    data_d.meta.x       = x_i;
    data_d.meta.m       = $signed(7'(q) - 7'd45);
    data_d.r            = {2'b00, mant} << rem[1:0];
    data_d.y            = COEF[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

[src/bcr_cell.sv]
// One Horner cell: multiply by the scaled significand, round, add a coefficient.
`timescale 1ns / 1ps
`default_nettype none

module bcr_cell
  import bcr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire acc_t coef_i,
  input  wire logic valid_i,
  output logic      ready_o,
  input  wire cell_t data_i,
  output logic      valid_o,
  input  wire logic ready_i,
  output cell_t     data_o
);

  logic                 valid_q, valid_d;
  logic                 load;
  cell_t                data_q, data_d;
  logic signed [Y_W+10:0] prod;
  logic signed [Y_W+10:0] rnd;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load ? 1'b1 : (ready_i ? 1'b0 : valid_q);

  // The product carries 47 fraction bits; round half up back to 40.
  assign prod = (Y_W+11)'(data_i.y) * (Y_W+11)'($signed({1'b0, data_i.r}));
  assign rnd  = prod + (Y_W+11)'(64);

  always_comb begin
    data_d      = data_i;
    data_d.y    = $signed(rnd[Y_W+6:7]) + coef_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

[src/bcr_norm.sv]
// Normalize stage: clamps the polynomial value positive and finds its leading one.
`timescale 1ns / 1ps
`default_nettype none

module bcr_norm
  import bcr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  output logic       ready_o,
  input  wire cell_t data_i,
  output logic       valid_o,
  input  wire logic  ready_i,
  output norm_t      data_o
);

  logic  valid_q, valid_d;
  logic  load;
  norm_t data_q, data_d;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load ? 1'b1 : (ready_i ? 1'b0 : valid_q);

  always_comb begin
    logic [Y_W-1:0] v;
    logic [K_W-1:0] k;
    if (data_i.y[Y_W-1] || (data_i.y == '0)) begin
      v = Y_W'(1);
    end else begin
      v = data_i.y;
    end
    k = '0;
    for (int i = 0; i < Y_W; i++) begin
      if (v[i]) begin
        k = K_W'(i);
      end
    end
    data_d.meta = data_i.meta;
    data_d.v    = v;
    data_d.k    = k;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

[src/bcr_pack.sv]
// Output stage: rounds to nearest even, forms the exponent and holds the result word.
`timescale 1ns / 1ps
`default_nettype none

module bcr_pack
  import bcr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  output logic       ready_o,
  input  wire norm_t data_i,
  output logic       valid_o,
  input  wire logic  ready_i,
  output logic [15:0] root_o
);

  logic        valid_q, valid_d;
  logic        load;
  logic [15:0] root_q, root_d;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load ? 1'b1 : (ready_i ? 1'b0 : valid_q);

  always_comb begin
    logic [K_W-1:0]   sh;
    logic [K_W-1:0]   shm1;
    logic [Y_W-1:0]   shifted;
    logic [Y_W-1:0]   lowmask;
    logic [7:0]       mant0;
    logic             inc;
    logic [8:0]       mant9;
    logic [7:0]       mant;
    logic             exinc;
    logic signed [9:0] biased;
    logic [7:0]       exp8;
    sh      = data_i.k - K_W'(7);
    shm1    = sh - K_W'(1);
    shifted = data_i.v >> sh;
    lowmask = ~({Y_W{1'b1}} << shm1);
    if (data_i.k >= K_W'(7)) begin
      mant0 = shifted[7:0];
      inc   = (sh != '0) && data_i.v[shm1]
              && ((|(data_i.v & lowmask)) || mant0[0]);
    end else begin
      mant0 = 8'(data_i.v[7:0] << (3'd7 - data_i.k[2:0]));
      inc   = 1'b0;
    end
    mant9 = {1'b0, mant0} + {8'd0, inc};
    exinc = mant9[8];
    mant  = exinc ? mant9[8:1] : mant9[7:0];
    // Exponent is m + k - 40, biased by 127.
    biased = $signed({{3{data_i.meta.m[M_W-1]}}, data_i.meta.m})
             + $signed({4'd0, data_i.k}) + 10'sd87 + $signed({9'd0, exinc});
    if (biased < 10'sd1) begin
      exp8 = 8'd1;
    end else if (biased > 10'sd254) begin
      exp8 = 8'd254;
    end else begin
      exp8 = biased[7:0];
    end
    if (data_i.meta.special) begin
      root_d = data_i.meta.x;
    end else begin
      root_d = {data_i.meta.x[15], exp8, mant[6:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      root_q <= root_d;
    end
  end

  assign valid_o = valid_q;
  assign root_o  = root_q;

endmodule

`default_nettype wire

[src/bfloat16_cube_root.sv]
// Top level of the bfloat16 cube root pipeline.
`timescale 1ns / 1ps
`default_nettype none
`include "bfloat16_cube_root_macros.svh"

// Computes the cube root of one bfloat16 word per clock while results are
// taken, keeping the sign and rounding to nearest even. Signed zeros,
// infinities and NaNs come back unchanged; subnormal operands are normalized
// before use. A new operand can be accepted every cycle unless a stalled
// result has filled every stage. A word passes through the register chain:
// one decode stage, six Horner cells that each perform a single multiply and
// round of the degree-6 polynomial, one normalize stage and the output
// register. Every stage holds its own valid bit and takes a new word whenever
// it is empty or its neighbor downstream takes its word, so a stalled result
// only blocks the chain once every stage is full, and bubbles close up by
// themselves. There is no state between words and nothing to configure.
module bfloat16_cube_root
  import bcr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bcr_in_if.sink    in_i,
  bcr_out_if.source out_o
);

  // Stage 0 is the decode output; stages 1 to NUM_CELLS are the Horner cells.
  cell_t stage_data  [NUM_CELLS+1];
  logic  stage_valid [NUM_CELLS+1];
  logic  stage_ready [NUM_CELLS+1];

  norm_t norm_data;
  logic  norm_valid;
  logic  norm_ready;

  bcr_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .x_i     (in_i.x_bits),
    .valid_o (stage_valid[0]),
    .ready_i (stage_ready[0]),
    .data_o  (stage_data[0])
  );

  // Each cell folds in the next coefficient, highest degree first.
  for (genvar g = 1; g <= NUM_CELLS; g++) begin : g_cell
    bcr_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .coef_i  (COEF[g]),
      .valid_i (stage_valid[g-1]),
      .ready_o (stage_ready[g-1]),
      .data_i  (stage_data[g-1]),
      .valid_o (stage_valid[g]),
      .ready_i (stage_ready[g]),
      .data_o  (stage_data[g])
    );
  end

  bcr_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stage_valid[NUM_CELLS]),
    .ready_o (stage_ready[NUM_CELLS]),
    .data_i  (stage_data[NUM_CELLS]),
    .valid_o (norm_valid),
    .ready_i (norm_ready),
    .data_o  (norm_data)
  );

  bcr_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (norm_valid),
    .ready_o (norm_ready),
    .data_i  (norm_data),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .root_o  (out_o.root_bits)
  );

  // With the output register empty, every stage can move, so the input must be open.
  `BCR_ASSERT_NOW(a_in_open_when_out_empty, !out_o.valid, in_i.ready,
    "input blocked although the output register is empty")

  // A word leaving the last Horner cell must land in the normalize stage.
  `BCR_ASSERT_NEXT(a_cell_to_norm,
    stage_valid[NUM_CELLS] && stage_ready[NUM_CELLS], norm_valid,
    "word lost between the last cell and the normalize stage")

  // A word leaving the normalize stage must show up as a result.
  `BCR_ASSERT_NEXT(a_norm_to_out, norm_valid && norm_ready, out_o.valid,
    "word lost between the normalize stage and the output register")

endmodule

`default_nettype wire

[verif/bfloat16_cube_root_tb.sv]
// Self-checking testbench for the bfloat16 cube root pipeline.
`timescale 1ns / 1ps

// The testbench drives operand words into the pipeline over the input stream
// and checks every result word against its own cube root predictor. It
// starts with a table of directed operands (signed zeros, infinities, NaNs
// with payloads, subnormals, the largest finite values and each exponent
// remainder), then sends random operands. Both sides idle at random, one
// draw per word, and the random part is split into phases with and without
// idling. Once the receiver stalls for a long stretch while the sender keeps
// offering words, so the pipeline fills up and holds off its input. Once the
// sender pauses until every expected result has come back.
module bfloat16_cube_root_tb;

  // Roughly 1700 random words follow the directed table.
  localparam int NUM_RANDOM  = 1700;
  localparam int NUM_PROBES  = 25;
  // Cycles to wait after the last result, to catch any stray word.
  localparam int DRAIN_WAIT  = 20;
  localparam int LONG_HOLD   = 80;
  localparam int BURST_WORDS = 60;
  localparam int HOLD_AT     = 300;
  localparam int PAUSE_AT    = 900;
  localparam int CYCLE_LIMIT = 500000;

  // Horner coefficients, highest degree first, scaled by 2^40.
  localparam longint HORNER_COEF [7] = '{
    -64'sd19100749,
    64'sd576262900,
    -64'sd7169741793,
    64'sd48233829404,
    -64'sd198312635322,
    64'sd632539573282,
    64'sd625192837686
  };

  // One row of the directed table. Where known_root is set, the expected
  // result is typed in; otherwise the predictor supplies it.
  typedef struct packed {
    logic [15:0] operand;
    logic        known_root;
    logic [15:0] root;
  } probe_t;

  probe_t probes [NUM_PROBES] = '{
    '{16'h0000, 1'b1, 16'h0000},  // positive zero
    '{16'h8000, 1'b1, 16'h8000},  // negative zero
    '{16'h7f80, 1'b1, 16'h7f80},  // positive infinity
    '{16'hff80, 1'b1, 16'hff80},  // negative infinity
    '{16'h7fc0, 1'b1, 16'h7fc0},  // quiet NaN
    '{16'hffff, 1'b1, 16'hffff},  // negative NaN, full payload
    '{16'h7f81, 1'b1, 16'h7f81},  // signaling NaN
    '{16'hffc1, 1'b1, 16'hffc1},  // negative NaN with payload
    '{16'h0001, 1'b0, 16'h0000},  // smallest subnormal
    '{16'h8001, 1'b0, 16'h0000},  // smallest negative subnormal
    '{16'h0003, 1'b0, 16'h0000},
    '{16'h0040, 1'b0, 16'h0000},  // subnormal with the top fraction bit set
    '{16'h007f, 1'b0, 16'h0000},  // largest subnormal
    '{16'h0080, 1'b0, 16'h0000},  // smallest normal
    '{16'h7f7f, 1'b0, 16'h0000},  // largest finite
    '{16'hff7f, 1'b0, 16'h0000},  // most negative finite
    '{16'h3f80, 1'b0, 16'h0000},  // one, remainder zero
    '{16'h4000, 1'b0, 16'h0000},  // two, remainder one
    '{16'h4080, 1'b0, 16'h0000},  // four, remainder two
    '{16'h4100, 1'b0, 16'h0000},  // eight
    '{16'hbf80, 1'b0, 16'h0000},  // minus one
    '{16'h3fff, 1'b0, 16'h0000},  // just below two
    '{16'h3e00, 1'b0, 16'h0000},  // one eighth
    '{16'h5a5a, 1'b0, 16'h0000},
    '{16'ha5a5, 1'b0, 16'h0000}
  };

  logic clk_i;
  logic rst_ni;

  bcr_in_if  operand_bus ();
  bcr_out_if root_bus ();

  bfloat16_cube_root DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (operand_bus),
    .out_o  (root_bus)
  );

  // Expected result words, oldest first, pushed when an operand is accepted.
  logic [15:0] expected_roots [$];
  int          mismatches  = 0;
  int          cycle_count = 0;
  // Set by the sender when it starts a burst; the receiver then holds off.
  bit          hold_request = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Cube root of one bfloat16 word in the same fixed point as the pipeline:
  // 40 fraction bits in the Horner accumulator, each product rounded half up,
  // and a final round to nearest even on the 7-bit fraction.
  function automatic logic [15:0] predict_root(input logic [15:0] x);
    logic [7:0]  exp_field;
    logic [6:0]  frac_field;
    logic [7:0]  signif;
    logic [7:0]  biased_exp;
    logic [63:0] acc_bits;
    logic [63:0] mant;
    logic [63:0] rem;
    logic [63:0] half;
    longint      acc;
    longint      scaled;
    int          e;
    int          rmd;
    int          third;
    int          p;
    int          k;
    int          ex;
    int          sh;
    int          biased;
    exp_field  = x[14:7];
    frac_field = x[6:0];
    // Signed zeros and the all-ones exponent pass straight through.
    if (x[14:0] == 15'd0) begin
      return x;
    end
    if (exp_field == 8'hff) begin
      return x;
    end
    if (exp_field == 8'd0) begin
      // Subnormal: shift the leading one up to the hidden bit position.
      p = 6;
      while (p > 0 && frac_field[p] == 1'b0) begin
        p--;
      end
      signif = 8'(16'(frac_field) << (7 - p));
      e      = p - 133;
    end else begin
      signif = {1'b1, frac_field};
      e      = int'(exp_field) - 127;
    end
    rmd    = ((e % 3) + 3) % 3;
    third  = (e - rmd) / 3;
    scaled = longint'(64'(signif) << rmd);
    acc    = HORNER_COEF[0];
    for (int i = 1; i < 7; i++) begin
      acc = ((acc * scaled + 64) >>> 7) + HORNER_COEF[i];
    end
    if (acc < 1) begin
      acc = 1;
    end
    acc_bits = acc;
    k = 63;
    while (k > 0 && acc_bits[k] == 1'b0) begin
      k--;
    end
    ex = third + k - 40;
    if (k >= 7) begin
      sh   = k - 7;
      mant = acc_bits >> sh;
      if (sh > 0) begin
        rem  = acc_bits & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && mant[0])) begin
          mant = mant + 64'd1;
        end
      end
    end else begin
      mant = acc_bits << (7 - k);
    end
    // Rounding can carry into a ninth significand bit.
    if (mant >= 64'd256) begin
      mant = mant >> 1;
      ex++;
    end
    biased = ex + 127;
    if (biased < 1) begin
      biased = 1;
    end
    if (biased > 254) begin
      biased = 254;
    end
    biased_exp = 8'(biased);
    return {x[15], biased_exp, mant[6:0]};
  endfunction

  // Operands for the random part: fully random words, normal values near
  // one, subnormals, specials and the edges of the exponent range.
  function automatic logic [15:0] draw_operand();
    int unsigned pick;
    logic [15:0] w;
    pick = $urandom_range(99);
    w    = 16'($urandom);
    if (pick < 45) begin
      // Keep the fully random word.
    end else if (pick < 70) begin
      w[14:7] = 8'($urandom_range(157, 97));
    end else if (pick < 85) begin
      w[14:7] = 8'h00;
    end else if (pick < 93) begin
      w[14:7] = 8'hff;
    end else begin
      w[14:7] = pick[0] ? 8'h01 : 8'hfe;
    end
    return w;
  endfunction

  // Idle cycles before one word: none, a uniform random count, or mostly none.
  function automatic int draw_wait(input int mode);
    if (mode == 0) begin
      return 0;
    end
    if (mode == 1) begin
      return $urandom_range(16);
    end
    return ($urandom_range(3) == 0) ? $urandom_range(16) : 0;
  endfunction

  // Offers one operand word after the given number of idle cycles and
  // returns at the edge where it is accepted. The task is entered at a clock
  // edge, and valid is assigned at most once per edge, so a word that
  // follows with no gap keeps valid high without a glitch.
  task automatic send_operand(input logic [15:0] operand, input int gap,
                              input logic known_root, input logic [15:0] root);
    if (gap > 0) begin
      operand_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    operand_bus.valid  <= 1'b1;
    operand_bus.x_bits <= operand;
    do begin
      @(posedge clk_i);
    end while (!operand_bus.ready);
    expected_roots.push_back(known_root ? root : predict_root(operand));
  endtask

  // Sender: directed table first, then random phases.
  initial begin
    int mode;
    int burst_left;
    operand_bus.valid  <= 1'b0;
    operand_bus.x_bits <= 16'h0000;
    root_bus.ready     <= 1'b0;
    rst_ni             <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_PROBES; i++) begin
      send_operand(probes[i].operand, draw_wait(1), probes[i].known_root,
                   probes[i].root);
    end

    mode       = 1;
    burst_left = 0;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      // A new idling pattern every hundred words.
      if (i % 100 == 0) begin
        mode = $urandom_range(2);
      end
      // Back-to-back words while the receiver holds off, so that every
      // stage fills and the input stalls.
      if (i == HOLD_AT) begin
        hold_request = 1'b1;
        burst_left   = BURST_WORDS;
      end
      // Let the pipeline run dry before going on.
      if (i == PAUSE_AT) begin
        operand_bus.valid <= 1'b0;
        do begin
          @(posedge clk_i);
        end while (expected_roots.size() != 0);
      end
      if (burst_left > 0) begin
        burst_left--;
        send_operand(draw_operand(), 0, 1'b0, 16'h0000);
      end else begin
        send_operand(draw_operand(), draw_wait(mode), 1'b0, 16'h0000);
      end
    end
    operand_bus.valid <= 1'b0;

    while (expected_roots.size() != 0) begin
      @(posedge clk_i);
    end
    // Any stray word after the last expected one is caught by the checker.
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Receiver: draws a stall before each result word and takes one long
  // hold when the sender asks for it.
  initial begin
    int stall;
    int mode;
    int taken;
    taken = 0;
    mode  = 1;
    repeat (4) @(posedge clk_i);
    forever begin
      if (taken % 50 == 0) begin
        mode = $urandom_range(2);
      end
      stall = draw_wait(mode);
      if (hold_request) begin
        hold_request = 1'b0;
        stall        = LONG_HOLD;
      end
      if (stall > 0) begin
        root_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      root_bus.ready <= 1'b1;
      do begin
        @(posedge clk_i);
      end while (!root_bus.valid);
      taken++;
    end
  end

  // Checker: every accepted result word against the oldest expectation.
  always @(posedge clk_i) begin
    logic [15:0] want;
    if (rst_ni && root_bus.valid && root_bus.ready) begin
      if (expected_roots.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word, expected none, actual %h",
                 $time, root_bus.root_bits);
      end else begin
        want = expected_roots.pop_front();
        if (root_bus.root_bits !== want) begin
          mismatches++;
          $display("%0t: root_bits mismatch, expected %h, actual %h",
                   $time, want, root_bus.root_bits);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d result words outstanding", $time,
               expected_roots.size());
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
